/* sv/pal_pkg.sv */
// shared widths and constants for the polyline arc length block
`default_nettype none
package pal_pkg;
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int COORD_W = 16;
  localparam int VTX_W = 3 * COORD_W;
  localparam int IDX_W = 6;
  localparam int FRAC_W = 16;
  localparam int SQ_W = 2 * COORD_W + 2;
  localparam int RAD_W = SQ_W + 16;
  localparam int SEG_W = RAD_W / 2;
  localparam int TOT_W = SEG_W + ADDR_W;
  localparam int NUM_W = TOT_W + FRAC_W;
  localparam int SUM_W = COORD_W + ADDR_W + 1;
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FINISH = 1'b1;
endpackage
`default_nettype wire

/* sv/pal_sqrt.sv */
// iterative integer square root, one root bit per cycle
`default_nettype none
module pal_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pal_pkg::RAD_W-1:0]     rad,
  output logic      [pal_pkg::SEG_W-1:0]     root,
  output logic                               done
);
  localparam int REM_W = pal_pkg::SEG_W + 2;
  localparam int CW = $clog2(pal_pkg::SEG_W + 1);

  logic [pal_pkg::RAD_W-1:0] r;
  logic [pal_pkg::SEG_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [CW-1:0] cnt;
  logic run;
  logic ge;

  assign rem_sh = {rem, r[pal_pkg::RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign ge = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r <= rad;
        rem <= '0;
        root <= '0;
        cnt <= CW'(pal_pkg::SEG_W);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? pal_pkg::SEG_W'(rem_sh - trial) : rem_sh[pal_pkg::SEG_W-1:0];
        root <= {root[pal_pkg::SEG_W-2:0], ge};
        r <= {r[pal_pkg::RAD_W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/pal_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module pal_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pal_pkg::NUM_W-1:0]     num,
  input  wire logic [pal_pkg::TOT_W-1:0]     den,
  output logic      [pal_pkg::NUM_W-1:0]     quot,
  output logic                               done
);
  localparam int DW = pal_pkg::TOT_W;
  localparam int CW = $clog2(pal_pkg::NUM_W + 1);

  logic [DW-1:0] rem;
  logic [DW:0] trial;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic run;
  logic ge;

  assign trial = {rem, quot[pal_pkg::NUM_W-1]};
  assign ge = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quot <= num;
        d <= den;
        cnt <= CW'(pal_pkg::NUM_W);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
        quot <= {quot[pal_pkg::NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/polyline_arc_length_param_top.sv */
// polyline arc length parameterisation: store, sequencer and result registers
//
// channel   direction  handshake            fields
// command   in         start, busy          op, x_in, y_in, z_in
// result    out        strobe (one cycle)   point_index .. last
//
// a load leaves busy low, so loads stream one per cycle.
// a finish with n vertices walks the store twice: per segment the multiply
// steps and a square root, then two centroid divides, then a divide for each
// vertex after the first unless the perimeter is zero, in the one-bit-per-cycle divider.
// an empty finish gives its single result in the cycle after it is taken.
// the receiver cannot stall: each result item is marked by strobe for a single cycle.
// rst is synchronous and clears count, overflow flag and sequencer.
`default_nettype none
module polyline_arc_length_param_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                op,
  input  wire logic signed [pal_pkg::COORD_W-1:0]  x_in,
  input  wire logic signed [pal_pkg::COORD_W-1:0]  y_in,
  input  wire logic signed [pal_pkg::COORD_W-1:0]  z_in,
  output logic                                     strobe,
  output logic        [pal_pkg::IDX_W-1:0]         point_index,
  output logic        [pal_pkg::FRAC_W-1:0]        tex_coord,
  output logic signed [pal_pkg::COORD_W-1:0]       min_x,
  output logic signed [pal_pkg::COORD_W-1:0]       max_x,
  output logic signed [pal_pkg::COORD_W-1:0]       min_y,
  output logic signed [pal_pkg::COORD_W-1:0]       max_y,
  output logic signed [pal_pkg::COORD_W-1:0]       center_x,
  output logic signed [pal_pkg::COORD_W-1:0]       center_y,
  output logic                                     empty_res,
  output logic                                     overflow,
  output logic                                     last
);
  localparam int CW = pal_pkg::COORD_W;
  localparam int AW = pal_pkg::ADDR_W;
  localparam int NW = pal_pkg::CNT_W;
  localparam int TW = pal_pkg::TOT_W;
  localparam int UW = pal_pkg::NUM_W;
  localparam int SW = pal_pkg::SUM_W;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RD   = 14'b00000000000010,
    S_ACC  = 14'b00000000000100,
    S_MUL  = 14'b00000000001000,
    S_SQGO = 14'b00000000010000,
    S_SQWT = 14'b00000000100000,
    S_CXGO = 14'b00000001000000,
    S_CXWT = 14'b00000010000000,
    S_CYGO = 14'b00000100000000,
    S_CYWT = 14'b00001000000000,
    S_ORD  = 14'b00010000000000,
    S_OACC = 14'b00100000000000,
    S_ODGO = 14'b01000000000000,
    S_ODWT = 14'b10000000000000
  } state_t;

  state_t state;
  logic [pal_pkg::VTX_W-1:0] vmem [pal_pkg::MAX_POINTS];
  logic [pal_pkg::SEG_W-1:0] smem [pal_pkg::MAX_POINTS];
  logic [pal_pkg::VTX_W-1:0] vtx_rd;
  logic [pal_pkg::SEG_W-1:0] seg_rd;

  logic [NW-1:0] count;
  logic ovf;
  logic [NW-1:0] i;
  logic [1:0] k;
  logic closing;
  logic [pal_pkg::VTX_W-1:0] first, prev, va, vb;
  logic signed [CW-1:0] mnx, mxx, mny, mxy, cx, cy;
  logic signed [SW-1:0] sx, sy;
  logic [pal_pkg::SQ_W-1:0] ssum;
  logic [2*CW-1:0] prod;
  logic [TW-1:0] total, cum;

  logic signed [CW-1:0] ca, cb;
  logic signed [CW:0] diff;
  logic [CW-1:0] mag;
  logic signed [CW-1:0] vx, vy;
  logic [SW-1:0] sx_mag, sy_mag;

  logic sq_start, sq_done;
  logic [pal_pkg::SEG_W-1:0] root;
  logic dv_start, dv_done;
  logic [UW-1:0] dv_num, dv_quot;
  logic [TW-1:0] dv_den;
  logic [CW-1:0] dv_mag;
  logic [pal_pkg::FRAC_W-1:0] tc_sat;

  assign busy = (state != S_IDLE);
  assign vx = vtx_rd[3*CW-1 -: CW];
  assign vy = vtx_rd[2*CW-1 -: CW];

  always_comb begin
    unique case (k)
      2'd0: begin
        ca = va[3*CW-1 -: CW];
        cb = vb[3*CW-1 -: CW];
      end
      2'd1: begin
        ca = va[2*CW-1 -: CW];
        cb = vb[2*CW-1 -: CW];
      end
      default: begin
        ca = va[CW-1:0];
        cb = vb[CW-1:0];
      end
    endcase
  end

  assign diff = {ca[CW-1], ca} - {cb[CW-1], cb};
  // |diff| never exceeds 65535, so the sign bit drops out
  assign mag = diff[CW] ? CW'(-diff) : diff[CW-1:0];

  assign sx_mag = sx[SW-1] ? -sx : sx;
  assign sy_mag = sy[SW-1] ? -sy : sy;

  assign sq_start = (state == S_SQGO);
  assign dv_start = (state == S_CXGO) || (state == S_CYGO) || (state == S_ODGO);

  always_comb begin
    dv_num = {cum, {pal_pkg::FRAC_W{1'b0}}};
    dv_den = total;
    if (state == S_CXGO) begin
      dv_num = {{(UW-SW){1'b0}}, sx_mag};
      dv_den = {{(TW-NW){1'b0}}, count};
    end else if (state == S_CYGO) begin
      dv_num = {{(UW-SW){1'b0}}, sy_mag};
      dv_den = {{(TW-NW){1'b0}}, count};
    end
  end

  assign dv_mag = dv_quot[CW-1:0];
  // fraction of one saturates
  assign tc_sat = (|dv_quot[UW-1:pal_pkg::FRAC_W]) ? '1 : dv_quot[pal_pkg::FRAC_W-1:0];

  pal_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   ({ssum, 16'd0}),
    .root  (root),
    .done  (sq_done)
  );

  pal_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .quot  (dv_quot),
    .done  (dv_done)
  );

  // stores, read data registered
  always_ff @(posedge clk) begin
    vtx_rd <= vmem[i[AW-1:0]];
    seg_rd <= smem[i[AW-1:0]];
    if (state == S_IDLE && start && op == pal_pkg::OP_LOAD &&
        count < NW'(pal_pkg::MAX_POINTS)) begin
      vmem[count[AW-1:0]] <= {x_in, y_in, z_in};
    end
    if (state == S_SQWT && sq_done && !closing) begin
      smem[i[AW-1:0]] <= root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf <= 1'b0;
      strobe <= 1'b0;
      i <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && op == pal_pkg::OP_LOAD) begin
            if (count < NW'(pal_pkg::MAX_POINTS)) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end else if (start && op == pal_pkg::OP_FINISH) begin
            if (count == '0) begin
              strobe <= 1'b1;
              point_index <= '0;
              tex_coord <= '0;
              min_x <= '0;
              max_x <= '0;
              min_y <= '0;
              max_y <= '0;
              center_x <= '0;
              center_y <= '0;
              empty_res <= 1'b1;
              overflow <= ovf;
              last <= 1'b1;
              ovf <= 1'b0;
            end else begin
              i <= '0;
              total <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_ACC;
        S_ACC: begin
          prev <= vtx_rd;
          va <= vtx_rd;
          vb <= prev;
          k <= '0;
          ssum <= '0;
          if (i == '0) begin
            first <= vtx_rd;
            mnx <= vx;
            mxx <= vx;
            mny <= vy;
            mxy <= vy;
            sx <= SW'(vx);
            sy <= SW'(vy);
            if (count == NW'(1)) begin
              vb <= vtx_rd;
              closing <= 1'b1;
              state <= S_MUL;
            end else begin
              i <= NW'(1);
              state <= S_RD;
            end
          end else begin
            if (vx < mnx) mnx <= vx;
            if (vx > mxx) mxx <= vx;
            if (vy < mny) mny <= vy;
            if (vy > mxy) mxy <= vy;
            sx <= sx + SW'(vx);
            sy <= sy + SW'(vy);
            closing <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // square one coordinate difference per cycle, add it the next
          if (k != 2'd0) ssum <= ssum + pal_pkg::SQ_W'(prod);
          if (k != 2'd3) prod <= mag * mag;
          k <= k + 1'b1;
          if (k == 2'd3) state <= S_SQGO;
        end
        S_SQGO: state <= S_SQWT;
        S_SQWT: begin
          if (sq_done) begin
            total <= total + TW'(root);
            if (closing) begin
              state <= S_CXGO;
            end else if (i == count - 1'b1) begin
              closing <= 1'b1;
              va <= first;
              vb <= prev;
              k <= '0;
              ssum <= '0;
              state <= S_MUL;
            end else begin
              i <= i + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_CXGO: state <= S_CXWT;
        S_CXWT: begin
          if (dv_done) begin
            cx <= sx[SW-1] ? -dv_mag : dv_mag;
            state <= S_CYGO;
          end
        end
        S_CYGO: state <= S_CYWT;
        S_CYWT: begin
          if (dv_done) begin
            cy <= sy[SW-1] ? -dv_mag : dv_mag;
            i <= '0;
            cum <= '0;
            state <= S_ORD;
          end
        end
        S_ORD: state <= S_OACC;
        S_OACC: begin
          if (i != '0) cum <= cum + TW'(seg_rd);
          if (i != '0 && total != '0) begin
            state <= S_ODGO;
          end else begin
            strobe <= 1'b1;
            point_index <= i[pal_pkg::IDX_W-1:0];
            tex_coord <= '0;
            min_x <= mnx;
            max_x <= mxx;
            min_y <= mny;
            max_y <= mxy;
            center_x <= cx;
            center_y <= cy;
            empty_res <= 1'b0;
            overflow <= ovf;
            last <= (i == count - 1'b1);
            if (i == count - 1'b1) begin
              count <= '0;
              ovf <= 1'b0;
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
              state <= S_ORD;
            end
          end
        end
        S_ODGO: state <= S_ODWT;
        S_ODWT: begin
          if (dv_done) begin
            strobe <= 1'b1;
            point_index <= i[pal_pkg::IDX_W-1:0];
            tex_coord <= tc_sat;
            min_x <= mnx;
            max_x <= mxx;
            min_y <= mny;
            max_y <= mxy;
            center_x <= cx;
            center_y <= cy;
            empty_res <= 1'b0;
            overflow <= ovf;
            last <= (i == count - 1'b1);
            if (i == count - 1'b1) begin
              count <= '0;
              ovf <= 1'b0;
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == pal_pkg::OP_LOAD) |=> !strobe)
    else $error("result after a load item");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("sequencer still running after last result");
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("sequencer stopped before last result");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && empty_res) |-> (last && tex_coord == '0))
    else $error("empty result not single");
endmodule
`default_nettype wire

/* verif/tb_polyline_arc_length_param_top.sv */
// self-checking testbench for the polyline arc length parameterisation block
`default_nettype none
module tb_polyline_arc_length_param_top;
  import pal_pkg::*;

  localparam int   CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [IDX_W-1:0]          point_index;
    logic [FRAC_W-1:0]         tex_coord;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic                      empty_res;
    logic                      overflow;
    logic                      last;
  } arc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = OP_LOAD;
  logic signed [COORD_W-1:0] x_in = '0, y_in = '0, z_in = '0;
  logic busy, strobe, empty_res, overflow, last;
  logic [IDX_W-1:0] point_index;
  logic [FRAC_W-1:0] tex_coord;
  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y, center_x, center_y;

  polyline_arc_length_param_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .x_in(x_in), .y_in(y_in), .z_in(z_in), .strobe(strobe),
    .point_index(point_index), .tex_coord(tex_coord),
    .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y),
    .center_x(center_x), .center_y(center_y),
    .empty_res(empty_res), .overflow(overflow), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [COORD_W-1:0] vx [MAX_POINTS];
  logic signed [COORD_W-1:0] vy [MAX_POINTS];
  logic signed [COORD_W-1:0] vz [MAX_POINTS];
  int unsigned stored_count = 0;
  bit dropped_flag = 0;
  arc_result_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int finishes_sent = 0;
  longint unsigned cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned segment_length(int a, int b);
    longint signed dx, dy, dz;
    longint unsigned s;
    dx = longint'(vx[a]) - longint'(vx[b]);
    dy = longint'(vy[a]) - longint'(vy[b]);
    dz = longint'(vz[a]) - longint'(vz[b]);
    s = dx * dx + dy * dy + dz * dz;
    return root_floor(s << 16);
  endfunction

  task automatic predict_arc(input logic cmd, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    arc_result_t r;
    int n;
    logic signed [COORD_W-1:0] mnx, mxx, mny, mxy;
    longint signed sx, sy;
    longint unsigned perim, cum, tc;
    n = stored_count;
    if (cmd == OP_LOAD) begin
      if (stored_count < MAX_POINTS) begin
        vx[stored_count] = x;
        vy[stored_count] = y;
        vz[stored_count] = z;
        stored_count++;
      end else begin
        dropped_flag = 1;
      end
      return;
    end
    if (n == 0) begin
      r = '0;
      r.empty_res = 1'b1;
      r.overflow = dropped_flag;
      r.last = 1'b1;
      pending_results.push_back(r);
      dropped_flag = 0;
      return;
    end
    mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
    sx = 0; sy = 0;
    for (int i = 0; i < n; i++) begin
      if (vx[i] < mnx) mnx = vx[i];
      if (vx[i] > mxx) mxx = vx[i];
      if (vy[i] < mny) mny = vy[i];
      if (vy[i] > mxy) mxy = vy[i];
      sx += vx[i];
      sy += vy[i];
    end
    perim = 0;
    for (int i = 1; i <= n; i++) perim += segment_length(i % n, i - 1);
    cum = 0;
    for (int i = 0; i < n; i++) begin
      tc = 0;
      if (i > 0) cum += segment_length(i, i - 1);
      if (perim > 0 && i > 0) begin
        tc = (cum << 16) / perim;
        if (tc > 64'hFFFF) tc = 64'hFFFF;
      end
      r.point_index = i[IDX_W-1:0];
      r.tex_coord = tc[FRAC_W-1:0];
      r.min_x = mnx; r.max_x = mxx; r.min_y = mny; r.max_y = mxy;
      r.center_x = COORD_W'(sx / longint'(n));
      r.center_y = COORD_W'(sy / longint'(n));
      r.empty_res = 1'b0;
      r.overflow = dropped_flag;
      r.last = (i == n - 1);
      pending_results.push_back(r);
    end
    stored_count = 0;
    dropped_flag = 0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    arc_result_t w;
    cycles <= cycles + 1;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, index", point_index, -1);
      end else begin
        w = pending_results.pop_front();
        if (point_index !== w.point_index) report_mismatch("point_index", point_index, w.point_index);
        if (tex_coord !== w.tex_coord) report_mismatch("tex_coord", tex_coord, w.tex_coord);
        if (min_x !== w.min_x) report_mismatch("min_x", min_x, w.min_x);
        if (max_x !== w.max_x) report_mismatch("max_x", max_x, w.max_x);
        if (min_y !== w.min_y) report_mismatch("min_y", min_y, w.min_y);
        if (max_y !== w.max_y) report_mismatch("max_y", max_y, w.max_y);
        if (center_x !== w.center_x) report_mismatch("center_x", center_x, w.center_x);
        if (center_y !== w.center_y) report_mismatch("center_y", center_y, w.center_y);
        if (empty_res !== w.empty_res) report_mismatch("empty_res", empty_res, w.empty_res);
        if (overflow !== w.overflow) report_mismatch("overflow", overflow, w.overflow);
        if (last !== w.last) report_mismatch("last", last, w.last);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one item: optional gap, then hold start until accepted
  task automatic send_item(input logic cmd, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z, input bit allow_gap);
    int gap;
    gap = allow_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= cmd;
    x_in <= x;
    y_in <= y;
    z_in <= z;
    do @(posedge clk); while (busy);
    predict_arc(cmd, x, y, z);
    items_sent++;
    if (cmd == OP_FINISH) finishes_sent++;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(int spread);
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return COORD_W'($urandom);
      default: return COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic test_edges;
    // empty finish, single point, zero perimeter
    send_item(OP_FINISH, 0, 0, 0, 0);
    send_item(OP_LOAD, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
    send_item(OP_FINISH, 0, 0, 0, 0);
    send_item(OP_LOAD, 5, 5, 5, 0);
    send_item(OP_LOAD, 5, 5, 5, 0);
    send_item(OP_FINISH, 0, 0, 0, 0);
    // extreme diagonal triangle
    send_item(OP_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_item(OP_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    send_item(OP_LOAD, 16'sh8000, 16'sh7FFF, 16'sh8000, 1);
    send_item(OP_FINISH, 0, 0, 0, 1);
    // closing segment of zero length: fraction saturates
    send_item(OP_LOAD, -3, 1, 0, 0);
    send_item(OP_LOAD, 4, -7, 2, 0);
    send_item(OP_LOAD, -3, 1, 0, 0);
    send_item(OP_FINISH, 0, 0, 0, 0);
  endtask

  task automatic test_overflow;
    for (int i = 0; i < MAX_POINTS + 3; i++)
      send_item(OP_LOAD, rand_coord(32768), rand_coord(32768), rand_coord(32768), 1);
    send_item(OP_FINISH, 0, 0, 0, 1);
    // overflow by one point on a full store, then a finish on the empty store
    for (int i = 0; i < MAX_POINTS + 1; i++)
      send_item(OP_LOAD, COORD_W'(-i), COORD_W'(i), 0, 0);
    send_item(OP_FINISH, 0, 0, 0, 0);
    send_item(OP_FINISH, 0, 0, 0, 0);
  endtask

  task automatic test_random_polylines;
    int n, spread;
    while (items_sent < 380) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_POINTS + 2)
                                       : $urandom_range(1, 8);
      spread = ($urandom_range(0, 1)) ? 100 : 32768;
      for (int i = 0; i < n; i++)
        send_item(OP_LOAD, rand_coord(spread), rand_coord(spread), rand_coord(spread), 1);
      send_item(OP_FINISH, 0, 0, 0, 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_overflow();
    test_random_polylines();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d items including %0d finishes", items_sent, finishes_sent);
    $display("checked %0d results", results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
